>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk_, rst_n_, expr_) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (expr_)) \
		else $error("assertion failed: always");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk_, rst_n_, ante_, cons_) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |-> (cons_)) \
		else $error("assertion failed: implies");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk_, rst_n_, ante_, cons_) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |=> (cons_)) \
		else $error("assertion failed: next");

`else

`define ASSERT_ALWAYS(lbl, clk_, rst_n_, expr_)
`define ASSERT_IMPLIES(lbl, clk_, rst_n_, ante_, cons_)
`define ASSERT_NEXT(lbl, clk_, rst_n_, ante_, cons_)

`endif

`endif

>>> hw/rtl/dstd_pkg.sv
// ----------------------------------------------------------------------------
// DMI structure table deframer package
// Register indexes, widths and the result record of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package dstd_pkg;

	localparam int unsigned OffW = 16;

	typedef enum logic [0:0] {
		REG_TABLE_LENGTH    = 1'b0,
		REG_STRUCTURE_LIMIT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [7:0]      entry_type;
		logic [7:0]      entry_length;
		logic [15:0]     entry_handle;
		logic [OffW-1:0] start_offset;
		logic [OffW-1:0] terminator_offset;
		logic            complete;
		logic            last;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/dmi_structure_table_deframer_top.sv
// ----------------------------------------------------------------------------
// DMI structure table deframer
// Walks a structure table byte by byte and reports each structure's header,
// start offset and terminator offset.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | table_byte, restart
//  out      | out_valid / out_ready| entry_type, entry_length, entry_handle,
//           |                      | start_offset, terminator_offset,
//           |                      | complete, last
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  One byte per cycle; each byte is parsed in the cycle it is accepted and
//  its result, if any, lands in a two-entry output queue.
//  in_ready depends only on the queue fill, so a byte is taken while one
//  result still waits; only a full queue stalls the input.
//  Reset leaves the parser stopped until a byte marked restart arrives.
//  A result appears on the outputs the cycle after its byte is accepted,
//  or once the result ahead of it has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmi_structure_table_deframer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  table_byte,
	input  wire logic        restart,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       entry_type,
	output logic [7:0]       entry_length,
	output logic [15:0]      entry_handle,
	output logic [15:0]      start_offset,
	output logic [15:0]      terminator_offset,
	output logic             complete,
	output logic             last
);

	localparam int unsigned W = dstd_pkg::OffW;

	// configuration
	logic [W-1:0] table_length_q;
	logic [W-1:0] structure_limit_q;

	// parser state
	logic [W-1:0] byte_offset_q;
	logic [W-1:0] structure_start_q;
	logic [7:0]   header_type_q;
	logic [7:0]   header_length_q;
	logic [15:0]  header_handle_q;
	logic         prev_zero_q;
	logic [W-1:0] seen_q;
	logic         stopped_q;

	// output queue
	dstd_pkg::result_t head_q;
	dstd_pkg::result_t tail_q;
	logic [1:0]        fill_q;

	// next-state signals
	logic [W-1:0] byte_offset_d;
	logic [W-1:0] structure_start_d;
	logic [7:0]   header_type_d;
	logic [7:0]   header_length_d;
	logic [15:0]  header_handle_d;
	logic         prev_zero_d;
	logic [W-1:0] seen_d;
	logic         stopped_d;

	logic [W-1:0] cur_off;
	logic [W-1:0] cur_start;
	logic [W-1:0] cur_seen;
	logic         cur_prev_zero;
	logic         cur_stopped;
	logic [7:0]   cur_type;
	logic [7:0]   cur_length;
	logic [15:0]  cur_handle;
	logic [W-1:0] rel;
	logic [W-1:0] rel_m1;
	logic [W:0]   off_p1;
	logic [W+1:0] off_p5;
	logic [W-1:0] seen_inc;
	logic         term;
	logic         trunc;
	logic         stop_after;

	logic              in_fire;
	logic              push;
	logic              pop;
	dstd_pkg::result_t push_data;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign in_fire   = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q    <= '0;
			structure_limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dstd_pkg::REG_TABLE_LENGTH:    table_length_q    <= cfg_data;
				dstd_pkg::REG_STRUCTURE_LIMIT: structure_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parse one byte
	always_comb begin
		// a restart byte wipes the walk before it is parsed
		if (restart) begin
			cur_off       = '0;
			cur_start     = '0;
			cur_seen      = '0;
			cur_prev_zero = 1'b0;
			cur_type      = '0;
			cur_length    = '0;
			cur_handle    = '0;
			cur_stopped   = (table_length_q < W'(4)) || (structure_limit_q == '0);
		end else begin
			cur_off       = byte_offset_q;
			cur_start     = structure_start_q;
			cur_seen      = seen_q;
			cur_prev_zero = prev_zero_q;
			cur_type      = header_type_q;
			cur_length    = header_length_q;
			cur_handle    = header_handle_q;
			cur_stopped   = stopped_q;
		end

		rel = cur_off - cur_start;
		header_type_d   = (rel == W'(0)) ? table_byte : cur_type;
		header_length_d = (rel == W'(1)) ? table_byte : cur_length;
		header_handle_d = cur_handle;
		if (rel == W'(2))
			header_handle_d[7:0] = table_byte;
		if (rel == W'(3))
			header_handle_d[15:8] = table_byte;

		rel_m1   = rel - W'(1);
		off_p1   = {1'b0, cur_off} + (W+1)'(1);
		off_p5   = {2'b00, cur_off} + (W+2)'(5);
		seen_inc = cur_seen + W'(1);

		term = !cur_stopped && (rel != '0) && (rel_m1 >= {8'h00, header_length_d})
			&& cur_prev_zero && (table_byte == 8'h00)
			&& (off_p1 <= {1'b0, table_length_q});
		trunc = !cur_stopped && !term && (off_p1 >= {1'b0, table_length_q});
		stop_after = (seen_inc >= structure_limit_q) || (off_p5 > {2'b00, table_length_q});

		push_data.entry_type        = header_type_d;
		push_data.entry_length      = header_length_d;
		push_data.entry_handle      = header_handle_d;
		push_data.start_offset      = cur_start;
		push_data.terminator_offset = term ? rel_m1 + cur_start : cur_off;
		push_data.complete          = term;
		push_data.last              = term ? stop_after : 1'b1;
		push                        = in_fire && (term || trunc);

		// defaults: keep restart effects, parse only when running
		byte_offset_d     = cur_off;
		structure_start_d = cur_start;
		seen_d            = cur_seen;
		prev_zero_d       = cur_prev_zero;
		stopped_d         = cur_stopped;
		if (!cur_stopped) begin
			byte_offset_d = off_p1[W-1:0];
			prev_zero_d   = (table_byte == 8'h00);
		end else begin
			header_type_d   = cur_type;
			header_length_d = cur_length;
			header_handle_d = cur_handle;
		end
		if (term) begin
			seen_d            = seen_inc;
			structure_start_d = off_p1[W-1:0];
			header_type_d     = '0;
			header_length_d   = '0;
			header_handle_d   = '0;
			stopped_d         = stop_after;
		end
		if (trunc)
			stopped_d = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q     <= '0;
			structure_start_q <= '0;
			header_type_q     <= '0;
			header_length_q   <= '0;
			header_handle_q   <= '0;
			prev_zero_q       <= 1'b0;
			seen_q            <= '0;
			stopped_q         <= 1'b1;
		end else if (in_fire) begin
			byte_offset_q     <= byte_offset_d;
			structure_start_q <= structure_start_d;
			header_type_q     <= header_type_d;
			header_length_q   <= header_length_d;
			header_handle_q   <= header_handle_d;
			prev_zero_q       <= prev_zero_d;
			seen_q            <= seen_d;
			stopped_q         <= stopped_d;
		end
	end

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			head_q <= (push && fill_q == 2'd1) ? push_data : tail_q;
			if (push && fill_q == 2'd2)
				tail_q <= push_data;
		end else if (push) begin
			if (fill_q == 2'd0)
				head_q <= push_data;
			else
				tail_q <= push_data;
		end
	end

	assign entry_type        = head_q.entry_type;
	assign entry_length      = head_q.entry_length;
	assign entry_handle      = head_q.entry_handle;
	assign start_offset      = head_q.start_offset;
	assign terminator_offset = head_q.terminator_offset;
	assign complete          = head_q.complete;
	assign last              = head_q.last;

	`ASSERT_ALWAYS(a_fill_range, clk, arst_n, fill_q != 2'd3)
	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, fill_q == 2'd2, !push)
	`ASSERT_NEXT(a_last_stops, clk, arst_n, push && push_data.last, stopped_q)
	`ASSERT_IMPLIES(a_quiet_stopped, clk, arst_n, in_fire && stopped_q && !restart, !push)
	`ASSERT_IMPLIES(a_trunc_last, clk, arst_n, push && !push_data.complete, push_data.last)

endmodule

`default_nettype wire
